// ----- hdl/ucw_pkg.sv -----
// Shared types, interval tables and width functions for the cell width block.
// No dependencies; every other file in hdl imports it.
package ucw_pkg;

    localparam int CP_W    = 21;
    localparam int CELLS_W = 2;
    localparam int AMB_W   = 2;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    typedef logic [CP_W-1:0]    t_cp;
    typedef logic [CELLS_W-1:0] t_cells;
    typedef logic [AMB_W-1:0]   t_amb;

    // register map, word index = byte address / 4
    typedef enum logic [0:0] {
        REG_AMBIGUOUS_WIDTH = 1'b0,
        REG_NONE            = 1'b1
    } t_reg_idx;

    localparam t_amb   AMB_RESET  = 2'd1;
    localparam t_amb   AMB_DOUBLE = 2'd2;

    localparam t_cells CELLS_ZERO   = 2'd0;
    localparam t_cells CELLS_NARROW = 2'd1;
    localparam t_cells CELLS_WIDE   = 2'd2;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
    } t_span;

    localparam int NONPRINT_N = 9;
    localparam int AMBIG_N    = 154;

    localparam t_span NONPRINT_TAB [NONPRINT_N] = '{
        '{16'h070f, 16'h070f}, '{16'h180b, 16'h180e}, '{16'h200b, 16'h200f},
        '{16'h202a, 16'h202e}, '{16'h206a, 16'h206f}, '{16'hd800, 16'hdfff},
        '{16'hfeff, 16'hfeff}, '{16'hfff9, 16'hfffb}, '{16'hfffe, 16'hffff}
    };

    localparam t_span AMBIG_TAB [AMBIG_N] = '{
        '{16'h00A1, 16'h00A1}, '{16'h00A4, 16'h00A4}, '{16'h00A7, 16'h00A8},
        '{16'h00AA, 16'h00AA}, '{16'h00AE, 16'h00AE}, '{16'h00B0, 16'h00B4},
        '{16'h00B6, 16'h00BA}, '{16'h00BC, 16'h00BF}, '{16'h00C6, 16'h00C6},
        '{16'h00D0, 16'h00D0}, '{16'h00D7, 16'h00D8}, '{16'h00DE, 16'h00E1},
        '{16'h00E6, 16'h00E6}, '{16'h00E8, 16'h00EA}, '{16'h00EC, 16'h00ED},
        '{16'h00F0, 16'h00F0}, '{16'h00F2, 16'h00F3}, '{16'h00F7, 16'h00FA},
        '{16'h00FC, 16'h00FC}, '{16'h00FE, 16'h00FE}, '{16'h0101, 16'h0101},
        '{16'h0111, 16'h0111}, '{16'h0113, 16'h0113}, '{16'h011B, 16'h011B},
        '{16'h0126, 16'h0127}, '{16'h012B, 16'h012B}, '{16'h0131, 16'h0133},
        '{16'h0138, 16'h0138}, '{16'h013F, 16'h0142}, '{16'h0144, 16'h0144},
        '{16'h0148, 16'h014B}, '{16'h014D, 16'h014D}, '{16'h0152, 16'h0153},
        '{16'h0166, 16'h0167}, '{16'h016B, 16'h016B}, '{16'h01CE, 16'h01CE},
        '{16'h01D0, 16'h01D0}, '{16'h01D2, 16'h01D2}, '{16'h01D4, 16'h01D4},
        '{16'h01D6, 16'h01D6}, '{16'h01D8, 16'h01D8}, '{16'h01DA, 16'h01DA},
        '{16'h01DC, 16'h01DC}, '{16'h0251, 16'h0251}, '{16'h0261, 16'h0261},
        '{16'h02C4, 16'h02C4}, '{16'h02C7, 16'h02C7}, '{16'h02C9, 16'h02CB},
        '{16'h02CD, 16'h02CD}, '{16'h02D0, 16'h02D0}, '{16'h02D8, 16'h02DB},
        '{16'h02DD, 16'h02DD}, '{16'h02DF, 16'h02DF}, '{16'h0391, 16'h03A1},
        '{16'h03A3, 16'h03A9}, '{16'h03B1, 16'h03C1}, '{16'h03C3, 16'h03C9},
        '{16'h0401, 16'h0401}, '{16'h0410, 16'h044F}, '{16'h0451, 16'h0451},
        '{16'h2010, 16'h2010}, '{16'h2013, 16'h2016}, '{16'h2018, 16'h2019},
        '{16'h201C, 16'h201D}, '{16'h2020, 16'h2022}, '{16'h2024, 16'h2027},
        '{16'h2030, 16'h2030}, '{16'h2032, 16'h2033}, '{16'h2035, 16'h2035},
        '{16'h203B, 16'h203B}, '{16'h203E, 16'h203E}, '{16'h2074, 16'h2074},
        '{16'h207F, 16'h207F}, '{16'h2081, 16'h2084}, '{16'h20AC, 16'h20AC},
        '{16'h2103, 16'h2103}, '{16'h2105, 16'h2105}, '{16'h2109, 16'h2109},
        '{16'h2113, 16'h2113}, '{16'h2116, 16'h2116}, '{16'h2121, 16'h2122},
        '{16'h2126, 16'h2126}, '{16'h212B, 16'h212B}, '{16'h2153, 16'h2154},
        '{16'h215B, 16'h215E}, '{16'h2160, 16'h216B}, '{16'h2170, 16'h2179},
        '{16'h2190, 16'h2199}, '{16'h21B8, 16'h21B9}, '{16'h21D2, 16'h21D2},
        '{16'h21D4, 16'h21D4}, '{16'h21E7, 16'h21E7}, '{16'h2200, 16'h2200},
        '{16'h2202, 16'h2203}, '{16'h2207, 16'h2208}, '{16'h220B, 16'h220B},
        '{16'h220F, 16'h220F}, '{16'h2211, 16'h2211}, '{16'h2215, 16'h2215},
        '{16'h221A, 16'h221A}, '{16'h221D, 16'h2220}, '{16'h2223, 16'h2223},
        '{16'h2225, 16'h2225}, '{16'h2227, 16'h222C}, '{16'h222E, 16'h222E},
        '{16'h2234, 16'h2237}, '{16'h223C, 16'h223D}, '{16'h2248, 16'h2248},
        '{16'h224C, 16'h224C}, '{16'h2252, 16'h2252}, '{16'h2260, 16'h2261},
        '{16'h2264, 16'h2267}, '{16'h226A, 16'h226B}, '{16'h226E, 16'h226F},
        '{16'h2282, 16'h2283}, '{16'h2286, 16'h2287}, '{16'h2295, 16'h2295},
        '{16'h2299, 16'h2299}, '{16'h22A5, 16'h22A5}, '{16'h22BF, 16'h22BF},
        '{16'h2312, 16'h2312}, '{16'h2460, 16'h24E9}, '{16'h24EB, 16'h254B},
        '{16'h2550, 16'h2573}, '{16'h2580, 16'h258F}, '{16'h2592, 16'h2595},
        '{16'h25A0, 16'h25A1}, '{16'h25A3, 16'h25A9}, '{16'h25B2, 16'h25B3},
        '{16'h25B6, 16'h25B7}, '{16'h25BC, 16'h25BD}, '{16'h25C0, 16'h25C1},
        '{16'h25C6, 16'h25C8}, '{16'h25CB, 16'h25CB}, '{16'h25CE, 16'h25D1},
        '{16'h25E2, 16'h25E5}, '{16'h25EF, 16'h25EF}, '{16'h2605, 16'h2606},
        '{16'h2609, 16'h2609}, '{16'h260E, 16'h260F}, '{16'h2614, 16'h2615},
        '{16'h261C, 16'h261C}, '{16'h261E, 16'h261E}, '{16'h2640, 16'h2640},
        '{16'h2642, 16'h2642}, '{16'h2660, 16'h2661}, '{16'h2663, 16'h2665},
        '{16'h2667, 16'h266A}, '{16'h266C, 16'h266D}, '{16'h266F, 16'h266F},
        '{16'h273D, 16'h273D}, '{16'h2776, 16'h277F}, '{16'hE000, 16'hF8FF},
        '{16'hFFFD, 16'hFFFD}
    };

    // true when cp sits in any of the spans; spans are compared in parallel
    function automatic logic in_nonprint(input t_cp cp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NONPRINT_N; i++) begin
            if (cp >= {5'd0, NONPRINT_TAB[i].lo} && cp <= {5'd0, NONPRINT_TAB[i].hi}) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic in_ambig(input t_cp cp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < AMBIG_N; i++) begin
            if (cp >= {5'd0, AMBIG_TAB[i].lo} && cp <= {5'd0, AMBIG_TAB[i].hi}) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_wide(input t_cp cp);
        return (cp >= 21'h01100 && cp <= 21'h0115f)
            || cp == 21'h02329 || cp == 21'h0232a
            || (cp >= 21'h02e80 && cp <= 21'h0a4cf && cp != 21'h0303f)
            || (cp >= 21'h0ac00 && cp <= 21'h0d7a3)
            || (cp >= 21'h0f900 && cp <= 21'h0faff)
            || (cp >= 21'h0fe30 && cp <= 21'h0fe6f)
            || (cp >= 21'h0ff00 && cp <= 21'h0ff60)
            || (cp >= 21'h0ffe0 && cp <= 21'h0ffe6)
            || (cp >= 21'h20000 && cp <= 21'h2fffd)
            || (cp >= 21'h30000 && cp <= 21'h3fffd);
    endfunction

    // rule priority: ASCII, C1 controls, non-printable, wide, ambiguous
    function automatic t_cells cell_width(input t_cp cp, input logic amb_double);
        t_cells w;
        if (cp < 21'h00080) begin
            w = CELLS_NARROW;
        end else if (cp < 21'h000a0) begin
            w = CELLS_ZERO;
        end else if (cp >= 21'h00100 && in_nonprint(cp)) begin
            w = CELLS_ZERO;
        end else if (cp >= 21'h00100 && is_wide(cp)) begin
            w = CELLS_WIDE;
        end else if (amb_double && in_ambig(cp)) begin
            w = CELLS_WIDE;
        end else begin
            w = CELLS_NARROW;
        end
        return w;
    endfunction

endpackage

// ----- hdl/ucw_if.sv -----
// Valid/ready channel interfaces for code point requests and cell width results.
// Depends on ucw_pkg.
interface ucw_cp_if;
    import ucw_pkg::*;
    logic valid;
    logic ready;
    t_cp  code_point;
    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

interface ucw_cells_if;
    import ucw_pkg::*;
    logic   valid;
    logic   ready;
    t_cells cells;
    modport source (output valid, output cells, input ready);
    modport sink   (input valid, input cells, output ready);
endinterface

// ----- hdl/unicode_char_cell_width.sv -----
// Pipeline: input register, then result register; the interval compares all sit between them.
// Throughput: one request per cycle unless the output stalls.
// Backpressure: each stage holds while full and the stage after it stalls.
// Reset (i_rst_n low, synchronous): both stages empty, ambiguous_width back to 1.
// Depends on ucw_pkg and ucw_if.sv; configured over a 32-bit APB-style port.
module unicode_char_cell_width (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ucw_cp_if.sink                        i_cp,
    ucw_cells_if.source                   o_cells,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ucw_pkg::APB_AW-1:0]    paddr,
    input  logic [ucw_pkg::APB_DW-1:0]    pwdata,
    output logic [ucw_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import ucw_pkg::*;

    // ambiguous width register
    t_amb     r_amb;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    // stage 1: captured code point
    logic   r_v1;
    t_cp    r_cp;
    // stage 2: result register
    logic   r_v2;
    t_cells r_cells;

    logic   s1_ready;
    logic   s2_ready;
    t_cells n_cells;

    // APB: word index from the byte address; only word 0 holds a register
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_AMBIGUOUS_WIDTH: prdata = {{(APB_DW-AMB_W){1'b0}}, r_amb};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amb <= AMB_RESET;
        end else if (cfg_wr && reg_idx == REG_AMBIGUOUS_WIDTH) begin
            r_amb <= pwdata[AMB_W-1:0];
        end
    end

    // Advance a stage whenever it is empty or the stage after it drains.
    assign s2_ready   = !r_v2 || o_cells.ready;
    assign s1_ready   = !r_v1 || s2_ready;
    assign i_cp.ready = s1_ready;

    // Only the value 2 selects double width; 0, 1 and 3 act as single width.
    assign n_cells = cell_width(r_cp, r_amb == AMB_DOUBLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_cp.valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    // payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_cp.valid) begin
            r_cp <= i_cp.code_point;
        end
        if (s2_ready && r_v1) begin
            r_cells <= n_cells;
        end
    end

    assign o_cells.valid = r_v2;
    assign o_cells.cells = r_cells;

    // a full input stage that moves must land in the result stage
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && s2_ready) |=> r_v2)
        else $error("request lost between stages");

    // a blocked input stage keeps its code point
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !s2_ready) |=> (r_v1 && $stable(r_cp)))
        else $error("stalled code point changed");

    // widths are 0, 1 or 2 only
    a_cells_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_cells != 2'd3))
        else $error("cell width out of range");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for unicode_char_cell_width: a directed table of code points,
// then random code points over several ambiguous_width settings, checked by a local predictor.
// Depends on ucw_pkg and the channel interfaces in hdl/ucw_if.sv.
module testbench;
    import ucw_pkg::*;

    localparam int LATENCY     = 2;     // input register plus result register
    localparam int STALL_LIMIT = 1000;  // cycles without any handshake before giving up
    localparam int PHASE_ITEMS = 90;    // random requests per ambiguous_width setting

    localparam logic [APB_AW-1:0] AMB_WIDTH_ADDR =
        APB_AW'(4 * int'(REG_AMBIGUOUS_WIDTH));

    // One row of the directed table. When typed is set, cells is the expected width;
    // otherwise the predictor supplies it.
    typedef struct packed {
        t_cp    cp;
        t_amb   amb;
        logic   typed;
        t_cells cells;
    } t_directed_row;

    typedef struct {
        t_cp    cp;
        t_cells cells;
    } t_pending_width;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ucw_cp_if    cp_bus ();
    ucw_cells_if cells_bus ();

    unicode_char_cell_width u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cp    (cp_bus),
        .o_cells (cells_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Span tables, upper half low bound, lower half high bound (both inclusive).
    bit [31:0] nonprint_spans [9] = '{
        32'h070F_070F, 32'h180B_180E, 32'h200B_200F, 32'h202A_202E, 32'h206A_206F,
        32'hD800_DFFF, 32'hFEFF_FEFF, 32'hFFF9_FFFB, 32'hFFFE_FFFF
    };

    // 0x303F sits inside the CJK span but is narrow; the predictor carves it out.
    bit [47:0] wide_spans [10] = '{
        48'h001100_00115F, 48'h002329_00232A, 48'h002E80_00A4CF, 48'h00AC00_00D7A3,
        48'h00F900_00FAFF, 48'h00FE30_00FE6F, 48'h00FF00_00FF60, 48'h00FFE0_00FFE6,
        48'h020000_02FFFD, 48'h030000_03FFFD
    };

    bit [31:0] ambig_spans [154] = '{
        32'h00A1_00A1, 32'h00A4_00A4, 32'h00A7_00A8, 32'h00AA_00AA, 32'h00AE_00AE,
        32'h00B0_00B4, 32'h00B6_00BA, 32'h00BC_00BF, 32'h00C6_00C6, 32'h00D0_00D0,
        32'h00D7_00D8, 32'h00DE_00E1, 32'h00E6_00E6, 32'h00E8_00EA, 32'h00EC_00ED,
        32'h00F0_00F0, 32'h00F2_00F3, 32'h00F7_00FA, 32'h00FC_00FC, 32'h00FE_00FE,
        32'h0101_0101, 32'h0111_0111, 32'h0113_0113, 32'h011B_011B, 32'h0126_0127,
        32'h012B_012B, 32'h0131_0133, 32'h0138_0138, 32'h013F_0142, 32'h0144_0144,
        32'h0148_014B, 32'h014D_014D, 32'h0152_0153, 32'h0166_0167, 32'h016B_016B,
        32'h01CE_01CE, 32'h01D0_01D0, 32'h01D2_01D2, 32'h01D4_01D4, 32'h01D6_01D6,
        32'h01D8_01D8, 32'h01DA_01DA, 32'h01DC_01DC, 32'h0251_0251, 32'h0261_0261,
        32'h02C4_02C4, 32'h02C7_02C7, 32'h02C9_02CB, 32'h02CD_02CD, 32'h02D0_02D0,
        32'h02D8_02DB, 32'h02DD_02DD, 32'h02DF_02DF, 32'h0391_03A1, 32'h03A3_03A9,
        32'h03B1_03C1, 32'h03C3_03C9, 32'h0401_0401, 32'h0410_044F, 32'h0451_0451,
        32'h2010_2010, 32'h2013_2016, 32'h2018_2019, 32'h201C_201D, 32'h2020_2022,
        32'h2024_2027, 32'h2030_2030, 32'h2032_2033, 32'h2035_2035, 32'h203B_203B,
        32'h203E_203E, 32'h2074_2074, 32'h207F_207F, 32'h2081_2084, 32'h20AC_20AC,
        32'h2103_2103, 32'h2105_2105, 32'h2109_2109, 32'h2113_2113, 32'h2116_2116,
        32'h2121_2122, 32'h2126_2126, 32'h212B_212B, 32'h2153_2154, 32'h215B_215E,
        32'h2160_216B, 32'h2170_2179, 32'h2190_2199, 32'h21B8_21B9, 32'h21D2_21D2,
        32'h21D4_21D4, 32'h21E7_21E7, 32'h2200_2200, 32'h2202_2203, 32'h2207_2208,
        32'h220B_220B, 32'h220F_220F, 32'h2211_2211, 32'h2215_2215, 32'h221A_221A,
        32'h221D_2220, 32'h2223_2223, 32'h2225_2225, 32'h2227_222C, 32'h222E_222E,
        32'h2234_2237, 32'h223C_223D, 32'h2248_2248, 32'h224C_224C, 32'h2252_2252,
        32'h2260_2261, 32'h2264_2267, 32'h226A_226B, 32'h226E_226F, 32'h2282_2283,
        32'h2286_2287, 32'h2295_2295, 32'h2299_2299, 32'h22A5_22A5, 32'h22BF_22BF,
        32'h2312_2312, 32'h2460_24E9, 32'h24EB_254B, 32'h2550_2573, 32'h2580_258F,
        32'h2592_2595, 32'h25A0_25A1, 32'h25A3_25A9, 32'h25B2_25B3, 32'h25B6_25B7,
        32'h25BC_25BD, 32'h25C0_25C1, 32'h25C6_25C8, 32'h25CB_25CB, 32'h25CE_25D1,
        32'h25E2_25E5, 32'h25EF_25EF, 32'h2605_2606, 32'h2609_2609, 32'h260E_260F,
        32'h2614_2615, 32'h261C_261C, 32'h261E_261E, 32'h2640_2640, 32'h2642_2642,
        32'h2660_2661, 32'h2663_2665, 32'h2667_266A, 32'h266C_266D, 32'h266F_266F,
        32'h273D_273D, 32'h2776_277F, 32'hE000_F8FF, 32'hFFFD_FFFD
    };

    // Directed requests. A change of amb between rows triggers a drain and a register write.
    t_directed_row directed_rows [24] = '{
        '{21'h000000, AMB_RESET,  1'b1, CELLS_NARROW},  // lowest code point, control char
        '{21'h00001F, AMB_RESET,  1'b1, CELLS_NARROW},  // control chars count as ASCII
        '{21'h00007F, AMB_RESET,  1'b1, CELLS_NARROW},  // DEL, top of ASCII
        '{21'h000080, AMB_RESET,  1'b1, CELLS_ZERO},    // first C1 control
        '{21'h00009F, AMB_RESET,  1'b1, CELLS_ZERO},    // last C1 control
        '{21'h0000A0, AMB_RESET,  1'b0, CELLS_NARROW},
        '{21'h0000A1, AMB_RESET,  1'b1, CELLS_NARROW},  // ambiguous, single width setting
        '{21'h00070F, AMB_RESET,  1'b1, CELLS_ZERO},    // format mark
        '{21'h00D800, AMB_RESET,  1'b1, CELLS_ZERO},    // surrogate
        '{21'h00FEFF, AMB_RESET,  1'b1, CELLS_ZERO},    // byte order mark
        '{21'h00FFFF, AMB_RESET,  1'b1, CELLS_ZERO},    // noncharacter
        '{21'h001100, AMB_RESET,  1'b1, CELLS_WIDE},    // Hangul Jamo
        '{21'h00303F, AMB_RESET,  1'b0, CELLS_NARROW},  // hole in the CJK span
        '{21'h00AC00, AMB_RESET,  1'b1, CELLS_WIDE},    // Hangul syllable
        '{21'h02FFFE, AMB_RESET,  1'b0, CELLS_NARROW},  // just past the plane 2 span
        '{21'h03FFFD, AMB_RESET,  1'b1, CELLS_WIDE},    // top of plane 3 span
        '{21'h0F0000, AMB_RESET,  1'b1, CELLS_NARROW},  // private use plane
        '{21'h10FFFF, AMB_RESET,  1'b1, CELLS_NARROW},  // highest scalar value
        '{21'h1FFFFF, AMB_RESET,  1'b1, CELLS_NARROW},  // beyond Unicode, all bits set
        '{21'h0000A1, AMB_DOUBLE, 1'b1, CELLS_WIDE},    // ambiguous, double width setting
        '{21'h00E000, AMB_DOUBLE, 1'b1, CELLS_WIDE},    // BMP private use is ambiguous
        '{21'h000080, AMB_DOUBLE, 1'b1, CELLS_ZERO},    // C1 wins over ambiguous
        '{21'h0000A1, 2'd0,       1'b1, CELLS_NARROW},  // register 0 acts as single
        '{21'h0000A1, 2'd3,       1'b1, CELLS_NARROW}   // register 3 acts as single
    };

    t_amb phase_settings [5] = '{AMB_DOUBLE, 2'd0, 2'd3, AMB_RESET, AMB_DOUBLE};

    t_amb           amb_setting = AMB_RESET;  // local copy of ambiguous_width
    t_pending_width expected_widths [$];
    int             mismatch_count = 0;
    int             idle_cycles = 0;
    int             burst_left = 0;
    logic [15:0]    stall_bits = 16'hFFFF;
    logic [5:0]     stall_age = 6'd0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Width of one code point under a given ambiguous_width setting.
    function automatic t_cells predict_cells(input t_cp cp, input t_amb amb);
        t_cells cells;
        logic   unprintable;
        logic   wide;
        logic   ambiguous;
        unprintable = 1'b0;
        wide = 1'b0;
        ambiguous = 1'b0;
        foreach (nonprint_spans[i]) begin
            if (cp >= nonprint_spans[i][31:16] && cp <= nonprint_spans[i][15:0]) begin
                unprintable = 1'b1;
            end
        end
        foreach (wide_spans[i]) begin
            if (cp >= wide_spans[i][47:24] && cp <= wide_spans[i][23:0]) begin
                wide = 1'b1;
            end
        end
        if (cp == 21'h0303F) begin
            wide = 1'b0;
        end
        foreach (ambig_spans[i]) begin
            if (cp >= ambig_spans[i][31:16] && cp <= ambig_spans[i][15:0]) begin
                ambiguous = 1'b1;
            end
        end
        // order matters: ASCII, C1, unprintable, wide, then ambiguous
        if (cp < 21'h00080) begin
            cells = CELLS_NARROW;
        end else if (cp < 21'h000A0) begin
            cells = CELLS_ZERO;
        end else if (cp >= 21'h00100 && unprintable) begin
            cells = CELLS_ZERO;
        end else if (cp >= 21'h00100 && wide) begin
            cells = CELLS_WIDE;
        end else if (amb == AMB_DOUBLE && ambiguous) begin
            cells = CELLS_WIDE;
        end else begin
            cells = CELLS_NARROW;
        end
        return cells;
    endfunction

    // Pick a point on or just outside the edges of a span, or somewhere inside it.
    function automatic t_cp span_edge_point(input int unsigned lo, input int unsigned hi);
        int unsigned point;
        case ($urandom_range(0, 4))
            0: point = lo - 1;
            1: point = lo;
            2: point = $urandom_range(hi, lo);
            3: point = hi;
            default: point = hi + 1;
        endcase
        return t_cp'(point);
    endfunction

    // Random code point, weighted toward table edges so every rule gets exercised.
    function automatic t_cp random_code_point();
        t_cp       cp;
        bit [31:0] span16;
        bit [47:0] span24;
        case ($urandom_range(0, 9))
            0, 1: cp = t_cp'($urandom);  // whole field, every bit toggles
            2: cp = t_cp'($urandom_range(0, 255));
            3: cp = t_cp'($urandom_range(0, 16'hFFFF));
            4, 5: begin
                span16 = ambig_spans[$urandom_range(0, $size(ambig_spans) - 1)];
                cp = span_edge_point(span16[31:16], span16[15:0]);
            end
            6: begin
                span16 = nonprint_spans[$urandom_range(0, $size(nonprint_spans) - 1)];
                cp = span_edge_point(span16[31:16], span16[15:0]);
            end
            7: begin
                span24 = wide_spans[$urandom_range(0, $size(wide_spans) - 1)];
                cp = span_edge_point(span24[47:24], span24[23:0]);
            end
            8: cp = t_cp'(21'h0303E + $urandom_range(0, 2));
            default: cp = t_cp'($urandom_range(21'h010000, 21'h1FFFFF));
        endcase
        return cp;
    endfunction

    task automatic report_mismatch(input string what, input t_cp cp, input t_cells want,
                                   input t_cells got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: code point %h expected %0d got %0d",
                     $time, what, cp, want, got);
        end
    endtask

    // Present one request, hold it until accepted, and queue its expected width.
    // Enter and leave at a falling edge.
    task automatic send_code_point(input t_cp cp, input logic typed, input t_cells typed_cells);
        int             gap;
        t_pending_width pending;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                cp_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        cp_bus.valid      <= 1'b1;
        cp_bus.code_point <= cp;
        do @(posedge i_clk); while (cp_bus.ready !== 1'b1);
        pending.cp    = cp;
        pending.cells = typed ? typed_cells : predict_cells(cp, amb_setting);
        expected_widths.push_back(pending);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Drop valid, let every outstanding request come back, then let the pipeline settle.
    task automatic settle_idle();
        cp_bus.valid <= 1'b0;
        burst_left = 0;
        while (expected_widths.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // Two-phase APB write of ambiguous_width; the upper data bits carry noise.
    task automatic write_ambiguous_width(input t_amb value);
        logic [APB_DW-1:0] data;
        data = $urandom;
        data[AMB_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AMB_WIDTH_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        amb_setting = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: rotate a 16-bit stall pattern, swap it when stall_age wraps. One mode never
    // stalls; the others always keep bit 0 set so no stall outlasts one turn of the pattern.
    always @(negedge i_clk) begin : rx_stall
        logic [15:0] bits;
        bits = stall_bits;
        if (stall_age == 6'd0) begin
            case ($urandom_range(0, 3))
                0: bits = 16'hFFFF;
                1: bits = 16'($urandom) | 16'h0001;
                2: bits = 16'($urandom & $urandom) | 16'h0001;
                default: bits = 16'($urandom | $urandom) | 16'h0001;
            endcase
        end
        cells_bus.ready <= bits[0];
        stall_bits      <= {bits[0], bits[15:1]};
        stall_age       <= stall_age + 6'd1;
    end

    // Compare each accepted result with the oldest pending expectation.
    always @(posedge i_clk) begin : width_check
        t_pending_width pending;
        if (i_rst_n === 1'b1 && cells_bus.valid === 1'b1 && cells_bus.ready === 1'b1) begin
            if (expected_widths.size() == 0) begin
                report_mismatch("result with no request pending", '0, '0, cells_bus.cells);
            end else begin
                pending = expected_widths.pop_front();
                if (cells_bus.cells !== pending.cells) begin
                    report_mismatch("cells mismatch", pending.cp, pending.cells,
                                    cells_bus.cells);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((cp_bus.valid === 1'b1 && cp_bus.ready === 1'b1)
            || (cells_bus.valid === 1'b1 && cells_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cp_bus.valid      = 1'b0;
        cp_bus.code_point = '0;

        // hold reset, then release it on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part; the first rows run on the reset value of the register
        foreach (directed_rows[r]) begin
            if (directed_rows[r].amb != amb_setting) begin
                settle_idle();
                write_ambiguous_width(directed_rows[r].amb);
            end
            send_code_point(directed_rows[r].cp, directed_rows[r].typed,
                            directed_rows[r].cells);
        end

        // random part, one burst of requests per register setting
        foreach (phase_settings[p]) begin
            settle_idle();
            write_ambiguous_width(phase_settings[p]);
            repeat (PHASE_ITEMS) begin
                send_code_point(random_code_point(), 1'b0, CELLS_NARROW);
            end
        end

        // drain, then give any stray result time to show up
        cp_bus.valid <= 1'b0;
        while (expected_widths.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
